@@ hdl/mptb_pkg.sv @@
// Shared types and constants for the pointer report to terminal byte block.
// Used by the front decoder, the run queue, the byte serializer and the top level.
// No dependencies.
package mptb_pkg;

  localparam int RUN_MAX = 5;
  localparam int RUN_LEN_W = $clog2(RUN_MAX + 1);
  localparam int RUN_IDX_W = $clog2(RUN_MAX);
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] ESC_BYTE = 8'h7e;
  localparam logic [7:0] KEY_MID = 8'h3f;
  localparam logic [7:0] KEY_RIGHT = 8'h40;

  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_TRACKPAD = 2'd1;
  localparam logic [1:0] KIND_EXT_MOUSE = 2'd2;
  localparam logic [1:0] KIND_EXT_BALL = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_ENABLE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_LENGTH = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_TARGETS = 2'd3;

  typedef struct packed {
    logic [7:0] report_byte0;
    logic [7:0] report_byte1;
    logic [7:0] report_byte2;
    logic [7:0] report_byte3;
    logic [3:0] byte_count;
    logic [1:0] device_kind;
  } report_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } tty_byte_t;

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [RUN_LEN_W-1:0]    len;
  } run_t;

endpackage

@@ hdl/mouse_packet_to_tty_bytes.sv @@
// Pointer report to terminal byte stream, top level.
// Each accepted report is decoded in the cycle it arrives and turned into a run
// of zero to five bytes; a run that is not empty waits in a short run queue and
// leaves one beat per cycle on the output channel while out_ready is high. The
// single byte output port sets the sustained rate; the next run, if one waits,
// starts in the cycle after the last beat of the run before it. Reports are
// taken back to back while the queue has room.
// Configuration writes are always ready and are meant to happen while idle.
// Instantiates mptb_front, mptb_queue and mptb_back; depends on mptb_pkg.
module mouse_packet_to_tty_bytes #(
  parameter int QUEUE_DEPTH = mptb_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mptb_pkg::report_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mptb_pkg::tty_byte_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mptb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mptb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic           push, full, pop, not_empty;
  mptb_pkg::run_t push_run, head;

  mptb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (full),
    .push       (push),
    .push_run   (push_run)
  );

  mptb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_run  (push_run),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  mptb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/mptb_front.sv @@
// Front end: configuration registers, report decode and button state tracking.
// Builds one run of up to five terminal bytes per report. Depends on mptb_pkg.
module mptb_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mptb_pkg::report_t                    in_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mptb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mptb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 queue_full,
  output logic                                 push,
  output mptb_pkg::run_t                       push_run
);

  logic        forward_enable;
  logic        map_enable;
  logic [2:0]  map_length;
  logic [15:0] map_targets;
  logic        left_state;
  logic        middle_state;
  logic        right_state;

  logic [7:0] b0, b1, b2, yb, xb;
  logic [3:0] cnt;
  logic [3:0] btns;
  logic [3:0] ext_btn;
  logic [3:0] tgt;
  logic [2:0] lim;
  logic [mptb_pkg::RUN_LEN_W-1:0] pos;
  logic       ext, up, bl, bm, br, chk_m, chk_r, mot, mchg, rchg, accept;

  assign in_ready = !queue_full;
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;

  always_comb begin
    b0 = in_data.report_byte0;
    b1 = in_data.report_byte1;
    b2 = in_data.report_byte2;
    cnt = in_data.byte_count;
    ext = (in_data.device_kind == mptb_pkg::KIND_EXT_MOUSE ||
           in_data.device_kind == mptb_pkg::KIND_EXT_BALL) && cnt == 4'd4;
    ext_btn = ~in_data.report_byte3[3:0];
    btns = 4'hf;
    tgt = 4'd0;
    up = 1'b1;
    lim = (map_length > 3'd4) ? 3'd4 : map_length;
    bl = 1'b1;
    bm = 1'b1;
    br = 1'b1;
    chk_m = 1'b1;
    chk_r = 1'b1;
    yb = b0;
    xb = b1;
    if (ext) begin
      if (in_data.device_kind == mptb_pkg::KIND_EXT_BALL) begin
        bl = !(ext_btn[2] || ext_btn[3]);
        bm = !ext_btn[0];
        br = !ext_btn[1];
      end else begin
        bl = !ext_btn[0];
        bm = !ext_btn[1];
        br = !ext_btn[2];
      end
      yb = {bl, b0[6:0]};
      xb = {1'b0, b1[6:0]};
    end else begin
      if (in_data.device_kind == mptb_pkg::KIND_TRACKPAD && cnt > 4'd1) begin
        b0 = {b0[7] & b1[7], b0[6:0]};
        b1 = {1'b1, b1[6:0]};
      end
      if (map_enable) begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < lim) begin
            tgt = map_targets[4*i +: 4];
            if (tgt >= 4'd1 && tgt <= 4'd4) begin
              up = 1'b1;
              if (i == 0) begin
                up = b0[7];
              end else if (i == 1) begin
                if (cnt >= 4'd1) up = b1[7];
              end else if (i == 2) begin
                if (cnt >= 4'd2) up = b2[7];
              end else begin
                if (cnt >= 4'd3) up = b2[3];
              end
              if (!up) btns[tgt[1:0] - 2'd1] = 1'b0;
            end
          end
        end
        b0 = {btns[0], b0[6:0]};
        b1 = {btns[1], b1[6:0]};
        b2 = {btns[2], b2[6:0]};
      end
      bl = b0[7];
      bm = b1[7];
      br = b2[7];
      chk_m = cnt >= 4'd2;
      chk_r = cnt >= 4'd3;
      yb = b0;
      xb = b1;
    end
    mot = (yb[6:0] != 7'd0) || (xb[6:0] != 7'd0) || (bl != left_state);
    mchg = chk_m && (bm != middle_state);
    rchg = chk_r && (br != right_state);

    push_run = '0;
    pos = '0;
    if (mot) begin
      push_run.bytes[0] = mptb_pkg::ESC_BYTE;
      push_run.bytes[1] = yb;
      push_run.bytes[2] = xb;
      pos = mptb_pkg::RUN_LEN_W'(3);
    end
    if (mchg) begin
      push_run.bytes[pos[mptb_pkg::RUN_IDX_W-1:0]] = {bm, mptb_pkg::KEY_MID[6:0]};
      pos = pos + 1'b1;
    end
    if (rchg) begin
      push_run.bytes[pos[mptb_pkg::RUN_IDX_W-1:0]] = {br, mptb_pkg::KEY_RIGHT[6:0]};
      pos = pos + 1'b1;
    end
    push_run.len = pos;
  end

  assign push = accept && forward_enable && (pos != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_enable <= 1'b0;
      map_enable <= 1'b0;
      map_length <= 3'd0;
      map_targets <= 16'd0;
      left_state <= 1'b1;
      middle_state <= 1'b1;
      right_state <= 1'b1;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          mptb_pkg::CFG_FORWARD_ENABLE: forward_enable <= cfg_data[0];
          mptb_pkg::CFG_MAP_ENABLE: map_enable <= cfg_data[0];
          mptb_pkg::CFG_MAP_LENGTH: map_length <= cfg_data[2:0];
          mptb_pkg::CFG_MAP_TARGETS: map_targets <= cfg_data;
          default: ;
        endcase
      end
      if (accept && forward_enable) begin
        if (mot) left_state <= bl;
        if (mchg) middle_state <= bm;
        if (rchg) right_state <= br;
      end
    end
  end

endmodule

@@ hdl/mptb_queue.sv @@
// Short queue of decoded byte runs between the front end and the serializer.
// Depends on mptb_pkg.
module mptb_queue #(
  parameter int DEPTH = mptb_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mptb_pkg::run_t push_run,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output mptb_pkg::run_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mptb_pkg::run_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign head = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

@@ hdl/mptb_back.sv @@
// Back end: takes one run from the queue and sends its bytes one beat at a time.
// Depends on mptb_pkg.
module mptb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  not_empty,
  input  mptb_pkg::run_t        head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mptb_pkg::tty_byte_t   out_data
);

  mptb_pkg::run_t cur;
  logic busy;
  logic [mptb_pkg::RUN_IDX_W-1:0] idx;
  logic last;

  assign last = idx == mptb_pkg::RUN_IDX_W'(cur.len - 1'b1);
  assign out_valid = busy;
  assign out_data.out_byte = cur.bytes[idx];
  assign out_data.last_of_run = last;
  assign pop = not_empty && (!busy || (out_ready && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (busy && out_ready) begin
      if (last) busy <= 1'b0;
      else idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

endmodule

@@ sim/tb_mouse_packet_to_tty_bytes.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for mouse_packet_to_tty_bytes: directed and random reports,
// a predictor of the terminal byte runs, and a byte-by-byte check of every output beat.
// Depends on mptb_pkg and the mouse_packet_to_tty_bytes top level.
module tb_mouse_packet_to_tty_bytes;

  localparam int DRAIN_CYCLES = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mptb_pkg::report_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mptb_pkg::tty_byte_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mptb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mptb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  mptb_pkg::report_t report_pending[$];
  mptb_pkg::tty_byte_t tty_expected[$];

  logic fwd_en = 1'b0;
  logic map_en = 1'b0;
  logic [2:0] map_len = 3'd0;
  logic [15:0] map_tgt = 16'h0000;
  logic left_up = 1'b1;
  logic middle_up = 1'b1;
  logic right_up = 1'b1;

  int error_count = 0;
  int reports_accepted = 0;
  int reports_sent = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  mouse_packet_to_tty_bytes u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] wanted);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, wanted);
    error_count++;
  endtask

  task automatic predict_tty_run(input mptb_pkg::report_t r);
    logic [7:0] b[3];
    logic [7:0] run_q[$];
    logic [3:0] cnt;
    logic [3:0] nib;
    logic [3:0] btns;
    logic [3:0] tgt;
    logic bl, bm, br, up;
    int lim;
    b[0] = r.report_byte0;
    b[1] = r.report_byte1;
    b[2] = r.report_byte2;
    cnt = r.byte_count;
    if (!fwd_en) return;
    if (r.device_kind >= mptb_pkg::KIND_EXT_MOUSE && cnt == 4'd4) begin
      nib = ~r.report_byte3[3:0];
      if (r.device_kind == mptb_pkg::KIND_EXT_BALL) begin
        bl = ~|(nib & 4'hc);
        bm = ~nib[0];
        br = ~nib[1];
      end else begin
        bl = ~nib[0];
        bm = ~nib[1];
        br = ~nib[2];
      end
      if (b[1][6:0] != 0 || b[0][6:0] != 0 || bl != left_up) begin
        run_q.push_back(mptb_pkg::ESC_BYTE);
        run_q.push_back({bl, b[0][6:0]});
        run_q.push_back({1'b0, b[1][6:0]});
        left_up = bl;
      end
      if (bm != middle_up) begin
        run_q.push_back({bm, mptb_pkg::KEY_MID[6:0]});
        middle_up = bm;
      end
      if (br != right_up) begin
        run_q.push_back({br, mptb_pkg::KEY_RIGHT[6:0]});
        right_up = br;
      end
    end else begin
      if (r.device_kind == mptb_pkg::KIND_TRACKPAD && cnt > 4'd1) begin
        b[0][7] = b[0][7] & b[1][7];
        b[1][7] = 1'b1;
      end
      if (map_en) begin
        btns = 4'hf;
        lim = (map_len < 3'd4) ? int'(map_len) : 4;
        for (int i = 0; i < lim; i++) begin
          tgt = map_tgt[4*i +: 4];
          if (tgt >= 4'd1 && tgt <= 4'd4) begin
            up = 1'b1;
            if (i < 3) begin
              if (int'(cnt) >= i) up = b[i][7];
            end else if (cnt >= 4'd3) begin
              up = b[2][3];
            end
            if (!up) btns[tgt - 4'd1] = 1'b0;
          end
        end
        for (int i = 0; i < 3; i++) b[i][7] = btns[i];
      end
      bl = b[0][7];
      bm = b[1][7];
      br = b[2][7];
      if (b[0][6:0] != 0 || b[1][6:0] != 0 || bl != left_up) begin
        run_q.push_back(mptb_pkg::ESC_BYTE);
        run_q.push_back(b[0]);
        run_q.push_back(b[1]);
        left_up = bl;
      end
      if (cnt >= 4'd2 && bm != middle_up) begin
        run_q.push_back({bm, mptb_pkg::KEY_MID[6:0]});
        middle_up = bm;
      end
      if (cnt >= 4'd3 && br != right_up) begin
        run_q.push_back({br, mptb_pkg::KEY_RIGHT[6:0]});
        right_up = br;
      end
    end
    for (int i = 0; i < run_q.size(); i++)
      tty_expected.push_back('{out_byte: run_q[i], last_of_run: (i == run_q.size() - 1)});
  endtask

  function automatic mptb_pkg::report_t mk_report(input logic [7:0] b0, input logic [7:0] b1,
                                                  input logic [7:0] b2, input logic [7:0] b3,
                                                  input logic [3:0] cnt,
                                                  input logic [1:0] kind);
    mptb_pkg::report_t r;
    r.report_byte0 = b0;
    r.report_byte1 = b1;
    r.report_byte2 = b2;
    r.report_byte3 = b3;
    r.byte_count = cnt;
    r.device_kind = kind;
    return r;
  endfunction

  function automatic mptb_pkg::report_t random_report();
    mptb_pkg::report_t r;
    r.report_byte0 = 8'($urandom_range(0, 255));
    r.report_byte1 = 8'($urandom_range(0, 255));
    r.report_byte2 = 8'($urandom_range(0, 255));
    r.report_byte3 = 8'($urandom_range(0, 255));
    r.device_kind = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 2) begin
      r.byte_count = 4'($urandom_range(0, 8));
    end else begin
      if (r.device_kind >= mptb_pkg::KIND_EXT_MOUSE)
        r.byte_count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(2, 3)) : 4'd4;
      else
        r.byte_count = 4'($urandom_range(2, 4));
      if ($urandom_range(0, 2) == 0) begin
        r.report_byte0[6:0] = 7'd0;
        r.report_byte1[6:0] = 7'd0;
      end
    end
    return r;
  endfunction

  task automatic write_reg(input logic [mptb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mptb_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mptb_pkg::CFG_FORWARD_ENABLE: fwd_en = val[0];
      mptb_pkg::CFG_MAP_ENABLE: map_en = val[0];
      mptb_pkg::CFG_MAP_LENGTH: map_len = val[2:0];
      mptb_pkg::CFG_MAP_TARGETS: map_tgt = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (report_pending.size() != 0 || in_valid || tty_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) report_pending.push_back(random_report());
    wait_idle();
  endtask

  task automatic random_map_setting();
    logic [15:0] tgts;
    for (int i = 0; i < 4; i++)
      tgts[4*i +: 4] = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 4))
                                                    : 4'($urandom_range(0, 15));
    write_reg(mptb_pkg::CFG_MAP_ENABLE, 16'd1);
    write_reg(mptb_pkg::CFG_MAP_LENGTH, 16'($urandom_range(0, 7)));
    write_reg(mptb_pkg::CFG_MAP_TARGETS, tgts);
  endtask

  // Sender: a new report goes out only after the previous beat was taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && reports_accepted < reports_sent) begin
    end else if (tx_idle > 0) begin
      in_valid <= 1'b0;
      tx_idle--;
    end else if (report_pending.size() > 0) begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        tx_idle = $urandom_range(1, 9) - 1;
        in_valid <= 1'b0;
      end else begin
        in_data <= report_pending.pop_front();
        in_valid <= 1'b1;
        reports_sent++;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (!hold_done && reports_accepted >= HOLD_AT) begin
      hold_cnt = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt--;
    end else if (rx_idle > 0) begin
      out_ready <= 1'b0;
      rx_idle--;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      rx_idle = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    mptb_pkg::tty_byte_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_tty_run(in_data);
        reports_accepted++;
      end
      if (out_valid && out_ready) begin
        if (tty_expected.size() == 0) begin
          report_mismatch("beat with no expected byte", out_data.out_byte, 8'h00);
        end else begin
          want = tty_expected.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_data.out_byte, want.out_byte);
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 8'(out_data.last_of_run), 8'(want.last_of_run));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With forwarding off nothing comes out and the button levels stay put.
    report_pending.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'hf0, 4'd3,
                                       mptb_pkg::KIND_PLAIN));
    report_pending.push_back(mk_report(8'h7f, 8'h7f, 8'h08, 8'h00, 4'd4,
                                       mptb_pkg::KIND_EXT_MOUSE));
    wait_idle();

    write_reg(mptb_pkg::CFG_FORWARD_ENABLE, 16'd1);
    report_pending.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 4'd3,
                                       mptb_pkg::KIND_PLAIN));
    report_pending.push_back(mk_report(8'hff, 8'hff, 8'hff, 8'hff, 4'd3,
                                       mptb_pkg::KIND_PLAIN));
    report_pending.push_back(mk_report(8'h80, 8'h80, 8'h80, 8'h80, 4'd3,
                                       mptb_pkg::KIND_PLAIN));
    report_pending.push_back(mk_report(8'h05, 8'h83, 8'h00, 8'h00, 4'd0,
                                       mptb_pkg::KIND_PLAIN));
    report_pending.push_back(mk_report(8'h80, 8'h00, 8'h80, 8'h00, 4'd1,
                                       mptb_pkg::KIND_PLAIN));
    report_pending.push_back(mk_report(8'h80, 8'h00, 8'h00, 8'h00, 4'd2,
                                       mptb_pkg::KIND_PLAIN));
    report_pending.push_back(mk_report(8'h80, 8'h00, 8'h80, 8'h00, 4'd2,
                                       mptb_pkg::KIND_TRACKPAD));
    report_pending.push_back(mk_report(8'h81, 8'h00, 8'h80, 8'h00, 4'd1,
                                       mptb_pkg::KIND_TRACKPAD));
    report_pending.push_back(mk_report(8'hff, 8'hff, 8'hff, 8'hff, 4'd8,
                                       mptb_pkg::KIND_TRACKPAD));
    report_pending.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'hf0, 4'd4,
                                       mptb_pkg::KIND_EXT_MOUSE));
    report_pending.push_back(mk_report(8'h7f, 8'h7f, 8'h7f, 8'hff, 4'd4,
                                       mptb_pkg::KIND_EXT_MOUSE));
    report_pending.push_back(mk_report(8'h80, 8'h80, 8'h80, 8'hf7, 4'd4,
                                       mptb_pkg::KIND_EXT_BALL));
    report_pending.push_back(mk_report(8'h80, 8'h80, 8'h80, 8'hfb, 4'd4,
                                       mptb_pkg::KIND_EXT_BALL));
    report_pending.push_back(mk_report(8'h80, 8'h80, 8'h80, 8'hfe, 4'd4,
                                       mptb_pkg::KIND_EXT_BALL));
    report_pending.push_back(mk_report(8'h80, 8'h80, 8'h80, 8'hfd, 4'd4,
                                       mptb_pkg::KIND_EXT_BALL));
    report_pending.push_back(mk_report(8'h00, 8'h80, 8'h00, 8'hff, 4'd3,
                                       mptb_pkg::KIND_EXT_MOUSE));
    report_pending.push_back(mk_report(8'hff, 8'h00, 8'h7f, 8'h00, 4'd8,
                                       mptb_pkg::KIND_EXT_BALL));
    wait_idle();

    // An enabled map with no entries in use reads every button as up.
    write_reg(mptb_pkg::CFG_MAP_ENABLE, 16'd1);
    report_pending.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 4'd3,
                                       mptb_pkg::KIND_PLAIN));
    wait_idle();

    write_reg(mptb_pkg::CFG_MAP_LENGTH, 16'd4);
    write_reg(mptb_pkg::CFG_MAP_TARGETS, 16'h1432);
    report_pending.push_back(mk_report(8'h00, 8'h80, 8'hf7, 8'h00, 4'd3,
                                       mptb_pkg::KIND_PLAIN));
    report_pending.push_back(mk_report(8'h80, 8'h00, 8'h00, 8'h00, 4'd2,
                                       mptb_pkg::KIND_PLAIN));
    report_pending.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 4'd0,
                                       mptb_pkg::KIND_TRACKPAD));
    wait_idle();

    write_reg(mptb_pkg::CFG_MAP_LENGTH, 16'd7);
    write_reg(mptb_pkg::CFG_MAP_TARGETS, 16'hffff);
    report_pending.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 4'd4,
                                       mptb_pkg::KIND_PLAIN));
    wait_idle();

    write_reg(mptb_pkg::CFG_MAP_ENABLE, 16'd0);
    run_random(150);

    repeat (4) begin
      random_map_setting();
      run_random(40);
    end

    write_reg(mptb_pkg::CFG_FORWARD_ENABLE, 16'd0);
    run_random(20);
    write_reg(mptb_pkg::CFG_FORWARD_ENABLE, 16'd1);

    write_reg(mptb_pkg::CFG_MAP_ENABLE, 16'd0);
    write_reg(mptb_pkg::CFG_MAP_LENGTH, 16'd0);
    write_reg(mptb_pkg::CFG_MAP_TARGETS, 16'h0000);
    no_idle = 1'b1;
    run_random(90);

    if (error_count == 0 && tty_expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
